// File: src/rgbc_pkg.sv
`default_nettype none
package rgbc_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int COEF_FRAC_BITS    = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam int FW_BITS  = 12;
  localparam int FH_BITS  = 13;
  localparam int ROW_BITS = 13;
  localparam int YL_BITS  = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_BITS  = 32;
  localparam int COEF_BITS = 16;
  localparam int GAIN_BITS = 24;
  localparam int BIAS_BITS = 19;
  localparam int TAPS      = 9;

  // accumulator: 9-bit signed pixel times 16-bit tap, nine terms
  localparam int PROD_BITS = 9 + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 4;
  localparam int SCL_BITS  = ACC_BITS + GAIN_BITS;
  localparam int TOT_BITS  = SCL_BITS + 1;
  localparam int BIAS_SH   = COEF_FRAC_BITS + 8;
  localparam int OUT_SH    = COEF_FRAC_BITS + 16;

  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_COEF_LO = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_HI = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_8  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_GAIN    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_BIAS    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CLAMP   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH   = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT  = 3'd7;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pixel_res_t;

  // neighbours already edge-resolved; an out-of-frame neighbour is zero unless clamp repeats the edge pixel
  typedef struct packed {
    logic [TAPS-1:0][PIX_BITS-1:0] taps;
    logic                          frame_end;
  } item_t;

  typedef logic [TAPS-1:0][COEF_BITS-1:0] coef_set_t;

  function automatic logic [7:0] saturate(input logic signed [SCL_BITS-1:0] scaled,
                                          input logic signed [BIAS_BITS-1:0] bias);
    logic signed [TOT_BITS-1:0] total;
    total = TOT_BITS'(scaled) + (TOT_BITS'(bias) <<< BIAS_SH);
    if (total[TOT_BITS-1]) begin
      return 8'd0;
    end else if (|total[TOT_BITS-2:OUT_SH+8]) begin
      return 8'hFF;
    end
    return total[OUT_SH+7:OUT_SH];
  endfunction

endpackage
`default_nettype wire

// File: src/rgbc_fifo.sv
`default_nettype none
module rgbc_fifo #(
  parameter int DEPTH = rgbc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire rgbc_pkg::item_t wdata,
  input  wire logic           rd,
  output rgbc_pkg::item_t     rdata,
  output logic                space,
  output logic                avail
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  rgbc_pkg::item_t  store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CNW-1:0]   count;

  assign space = (count != CNW'(DEPTH));
  assign avail = (count != '0);
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNW'(wr) - CNW'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && !space && !rd))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd && !avail))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNW'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// File: src/rgbc_front.sv
`default_nettype none
module rgbc_front #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         restart,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] w_last,
  input  wire logic [rgbc_pkg::YL_BITS-1:0] h_last,
  input  wire logic                         clamp,
  input  wire logic                         push,
  output logic                              full,
  input  wire rgbc_pkg::pixel_req_t         pixel,
  input  wire logic                         q_space,
  output logic                              q_push,
  output rgbc_pkg::item_t                   q_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PB = rgbc_pkg::PIX_BITS;
  localparam logic F_IDLE = 1'b0;
  localparam logic F_EXEC = 1'b1;

  logic                            state;
  logic [PB-1:0]                   pix_q;
  logic [2*PB-1:0]                 rd_q;
  logic [2*PB-1:0]                 line_store [MAX_WIDTH];
  logic [CW-1:0]                   col;
  logic [rgbc_pkg::ROW_BITS-1:0]   row;
  logic [CW-1:0]                   ox;
  logic [rgbc_pkg::YL_BITS-1:0]    oy;
  logic [rgbc_pkg::TAPS-1:0][PB-1:0] win;
  logic [rgbc_pkg::TAPS-1:0][PB-1:0] win_next;
  logic                            accept;
  logic                            ready;
  logic                            last;
  logic                            top, bottom, left, right;

  assign full   = (state == F_EXEC) || !q_space;
  assign accept = push && !full;
  assign ready  = (row >= 13'd2) || (row == 13'd1 && col != '0);
  assign top    = (oy == '0);
  assign bottom = (oy == h_last);
  assign left   = (ox == '0);
  assign right  = (ox == w_last);
  assign last   = right && bottom;
  assign q_push = (state == F_EXEC) && ready;

  always_comb begin
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = rd_q[2*PB-1:PB];
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = rd_q[PB-1:0];
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = pix_q;
  end

  always_comb begin
    int  r, c;
    logic outside;
    q_item.frame_end = last;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        r = 1 + dy;
        c = 1 + dx;
        outside = 1'b0;
        if ((dy < 0 && top) || (dy > 0 && bottom)) begin
          r = 1;
          outside = 1'b1;
        end
        if ((dx < 0 && left) || (dx > 0 && right)) begin
          c = 1;
          outside = 1'b1;
        end
        if (outside && !clamp) begin
          q_item.taps[(dy + 1) * 3 + dx + 1] = '0;
        end else begin
          q_item.taps[(dy + 1) * 3 + dx + 1] = win_next[r * 3 + c];
        end
      end
    end
  end

  // line store entry holds {older row, newer row} for one column
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q  <= line_store[col];
      pix_q <= (pixel.command == rgbc_pkg::CMD_FLUSH) ? '0 :
               {pixel.alpha_in, pixel.red_in, pixel.green_in, pixel.blue_in};
    end
    if (state == F_EXEC) begin
      line_store[col] <= {rd_q[PB-1:0], pix_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      ox    <= '0;
      oy    <= '0;
      win   <= '0;
    end else if (restart) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      ox    <= '0;
      oy    <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_EXEC;
          end
        end
        F_EXEC: begin
          state <= F_IDLE;
          win   <= win_next;
          if (col == w_last) begin
            col <= '0;
            if (row != '1) begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
          if (ready) begin
            if (last) begin
              col <= '0;
              row <= '0;
              ox  <= '0;
              oy  <= '0;
            end else if (right) begin
              ox <= '0;
              oy <= oy + 1'b1;
            end else begin
              ox <= ox + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst) q_push |-> q_space)
    else $error("front pushed into a full queue");
  a_exec_follows_accept: assert property (@(posedge clk) disable iff (rst || restart)
      accept |=> state == F_EXEC)
    else $error("accepted pixel not processed");
  a_col_in_range: assert property (@(posedge clk) disable iff (rst) col <= w_last)
    else $error("input column beyond frame width");

endmodule
`default_nettype wire

// File: src/rgbc_back.sv
`default_nettype none
module rgbc_back (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   q_avail,
  input  wire rgbc_pkg::item_t                        q_item,
  output logic                                        q_pop,
  input  wire rgbc_pkg::coef_set_t                    coef,
  input  wire logic signed [rgbc_pkg::GAIN_BITS-1:0] gain,
  input  wire logic signed [rgbc_pkg::BIAS_BITS-1:0] bias,
  output logic                                        empty,
  input  wire logic                                   pop,
  output rgbc_pkg::pixel_res_t                        result
);

  localparam int AW = rgbc_pkg::ACC_BITS;
  localparam int SW = rgbc_pkg::SCL_BITS;
  localparam int PB = rgbc_pkg::PIX_BITS;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MAC  = 2'd1;
  localparam logic [1:0] B_GAIN = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]                state;
  rgbc_pkg::item_t           item;
  logic [3:0]                t;
  logic [2:0]                k;
  logic signed [AW-1:0]      acc [4];
  logic signed [SW-1:0]      scaled;
  logic [3:0][7:0]           chan;
  logic                      out_valid;
  logic [PB-1:0]             px;
  logic signed [rgbc_pkg::COEF_BITS-1:0] kt;

  assign empty = !out_valid;
  assign q_pop = (state == B_IDLE) && q_avail;
  assign px    = item.taps[t];
  assign kt    = coef[t];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    unique case (state)
      B_IDLE: begin
        for (int ch = 0; ch < 4; ch++) begin
          acc[ch] <= '0;
        end
      end
      B_MAC: begin
        for (int ch = 0; ch < 4; ch++) begin
          acc[ch] <= acc[ch] + AW'($signed({1'b0, px[PB-1-8*ch -: 8]})) * AW'(kt);
        end
      end
      B_GAIN: begin
        if (k < 3'd4) begin
          scaled <= SW'(acc[k[1:0]]) * SW'(gain);
        end
        if (k != 3'd0) begin
          chan[2'(k - 3'd1)] <= rgbc_pkg::saturate(scaled, bias);
        end
      end
      B_DONE: begin
        if (!out_valid || pop) begin
          result <= '{alpha_out: chan[0], red_out: chan[1], green_out: chan[2],
                      blue_out: chan[3], frame_end: item.frame_end};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      t         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          t <= '0;
          if (q_avail) begin
            state <= B_MAC;
          end
        end
        B_MAC: begin
          t <= t + 1'b1;
          if (t == 4'(rgbc_pkg::TAPS - 1)) begin
            state <= B_GAIN;
            k     <= '0;
          end
        end
        B_GAIN: begin
          k <= k + 1'b1;
          if (k == 3'd4) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
      state == B_MAC |-> t < 4'(rgbc_pkg::TAPS))
    else $error("tap index out of range");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
      out_valid && !pop |=> out_valid && $stable(result))
    else $error("pending result lost or changed");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |=> state == B_MAC)
    else $error("popped item not started");

endmodule
`default_nettype wire

// File: src/rgba_3x3_convolution.sv
`default_nettype none
// RGBA 3x3 convolution over a raster-order frame; send frame_width + 1 flush
// requests after the last pixel to drain it. The front end takes a pixel
// request only when it is done with the last one (line store read, then
// write-back and window shift) and while the queue has space, and hands
// edge-resolved 3x3 neighbourhoods to a 2-entry queue. The back end takes one
// item at a time: it loads it, runs the multiply-accumulate over the nine
// taps (4 channels in parallel), then the gain multiply and saturation, and
// posts the result before it takes the next item. Results wait in an output
// register until popped. Config registers (64-bit APB, address 8*index) may
// only be written while the block is idle; writing width or height restarts
// the frame. No clearing pass is needed after reset.
module rgba_3x3_convolution #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rgbc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [rgbc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [rgbc_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                      pready,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire rgbc_pkg::pixel_req_t                 pixel,
  output logic                                      empty,
  input  wire logic                                 pop,
  output rgbc_pkg::pixel_res_t                      result
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [63:0]                          coef_lo;
  logic [63:0]                          coef_hi;
  logic [15:0]                          coef_8;
  logic [rgbc_pkg::GAIN_BITS-1:0]       gain;
  logic [rgbc_pkg::BIAS_BITS-1:0]       bias;
  logic                                 clamp;
  logic [rgbc_pkg::FW_BITS-1:0]         fw;
  logic [rgbc_pkg::FH_BITS-1:0]         fh;
  logic                                 wr;
  logic                                 restart;
  logic [rgbc_pkg::REG_IDX_BITS-1:0]    idx;
  logic [CW-1:0]                        w_last;
  logic [rgbc_pkg::YL_BITS-1:0]         h_last;
  rgbc_pkg::coef_set_t                  coef;
  logic                                 q_push, q_pop, q_space, q_avail;
  rgbc_pkg::item_t                      q_in, q_out;

  assign pready  = 1'b1;
  assign idx     = paddr[5:3];
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr && (idx == rgbc_pkg::REG_WIDTH || idx == rgbc_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_lo <= 64'd0;
      coef_hi <= 64'd256;
      coef_8  <= '0;
      gain    <= 24'd65536;
      bias    <= '0;
      clamp   <= 1'b1;
      fw      <= 12'd640;
      fh      <= 13'd480;
    end else if (wr) begin
      unique case (idx)
        rgbc_pkg::REG_COEF_LO: coef_lo <= pwdata;
        rgbc_pkg::REG_COEF_HI: coef_hi <= pwdata;
        rgbc_pkg::REG_COEF_8:  coef_8  <= pwdata[15:0];
        rgbc_pkg::REG_GAIN:    gain    <= pwdata[rgbc_pkg::GAIN_BITS-1:0];
        rgbc_pkg::REG_BIAS:    bias    <= pwdata[rgbc_pkg::BIAS_BITS-1:0];
        rgbc_pkg::REG_CLAMP:   clamp   <= pwdata[0];
        rgbc_pkg::REG_WIDTH:   fw      <= pwdata[rgbc_pkg::FW_BITS-1:0];
        rgbc_pkg::REG_HEIGHT:  fh      <= pwdata[rgbc_pkg::FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rgbc_pkg::REG_COEF_LO: prdata = coef_lo;
      rgbc_pkg::REG_COEF_HI: prdata = coef_hi;
      rgbc_pkg::REG_COEF_8:  prdata = 64'(coef_8);
      rgbc_pkg::REG_GAIN:    prdata = 64'(gain);
      rgbc_pkg::REG_BIAS:    prdata = 64'(bias);
      rgbc_pkg::REG_CLAMP:   prdata = 64'(clamp);
      rgbc_pkg::REG_WIDTH:   prdata = 64'(fw);
      rgbc_pkg::REG_HEIGHT:  prdata = 64'(fh);
      default:               prdata = '0;
    endcase
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (fw == '0) begin
      w_last = '0;
    end else if (int'(fw) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(fw - 12'd1);
    end
    if (fh == '0) begin
      h_last = '0;
    end else if (int'(fh) > rgbc_pkg::MAX_HEIGHT) begin
      h_last = rgbc_pkg::YL_BITS'(rgbc_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = rgbc_pkg::YL_BITS'(fh - 13'd1);
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      coef[n]     = coef_lo[16*n +: 16];
      coef[n + 4] = coef_hi[16*n +: 16];
    end
    coef[8] = coef_8;
  end

  rgbc_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .restart(restart),
    .w_last (w_last),
    .h_last (h_last),
    .clamp  (clamp),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .q_space(q_space),
    .q_push (q_push),
    .q_item (q_in)
  );

  rgbc_fifo #(
    .DEPTH(rgbc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .wdata(q_in),
    .rd   (q_pop),
    .rdata(q_out),
    .space(q_space),
    .avail(q_avail)
  );

  rgbc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_avail(q_avail),
    .q_item (q_out),
    .q_pop  (q_pop),
    .coef   (coef),
    .gain   ($signed(gain)),
    .bias   ($signed(bias)),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire
